// File: src/atacb_pkg.sv
package atacb_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE0_LBA_OK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE1_LBA_OK = 2'd1;

    // address boundary for lba48 and the chs and lba device-select bases
    localparam logic [31:0] LBA48_START = 32'h1000_0000;
    localparam logic [7:0]  DEVSEL_CHS  = 8'hA0;
    localparam logic [7:0]  DEVSEL_LBA  = 8'hE0;

    // reciprocal of 63 scaled by 2**34, exact for 28-bit dividends
    localparam int          CHS_ADDR_W  = 28;
    localparam int          RECIP_SHIFT = 34;
    localparam int          RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP_63 = 29'd272696337;
    localparam int          PROD_W      = CHS_ADDR_W + RECIP_W;
    localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

    // task-file register ids, in write order
    localparam logic [3:0] REG_DEVSEL   = 4'd0;
    localparam logic [3:0] REG_SCNT_HI  = 4'd1;
    localparam logic [3:0] REG_LBA3     = 4'd2;
    localparam logic [3:0] REG_LBA4     = 4'd3;
    localparam logic [3:0] REG_LBA5     = 4'd4;
    localparam logic [3:0] REG_SCNT_LO  = 4'd5;
    localparam logic [3:0] REG_LBA0     = 4'd6;
    localparam logic [3:0] REG_LBA1     = 4'd7;
    localparam logic [3:0] REG_LBA2     = 4'd8;
    localparam logic [3:0] REG_CMD      = 4'd9;

    // command opcodes
    localparam logic [7:0] OP_PIO_RD    = 8'h20;
    localparam logic [7:0] OP_PIO_RD_EXT = 8'h24;
    localparam logic [7:0] OP_DMA_RD    = 8'hC8;
    localparam logic [7:0] OP_DMA_RD_EXT = 8'h25;
    localparam logic [7:0] OP_PIO_WR    = 8'h30;
    localparam logic [7:0] OP_PIO_WR_EXT = 8'h34;
    localparam logic [7:0] OP_DMA_WR    = 8'hCA;
    localparam logic [7:0] OP_DMA_WR_EXT = 8'h35;

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } addr_mode_t;

    typedef struct packed {
        logic        drive_sel;
        logic        is_write;
        logic        use_dma;
        logic [31:0] sector_addr;
        logic [7:0]  sector_count;
    } req_t;

    typedef struct packed {
        logic [3:0] reg_id;
        logic [7:0] reg_value;
        logic [1:0] addr_mode;
        logic       last_write;
    } result_t;

    // everything the write sequencer needs for one command
    typedef struct packed {
        addr_mode_t mode;
        logic [7:0] devsel;
        logic [7:0] scnt_lo;
        logic [7:0] lba3;
        logic [7:0] lba0;
        logic [7:0] lba1;
        logic [7:0] lba2;
        logic [7:0] opcode;
    } frame_t;

    // opcode from direction, dma flag and extended addressing
    function automatic logic [7:0] opcode_sel(input logic wr, input logic dma,
                                              input logic ext);
        logic [7:0] op;
        unique case ({wr, dma, ext})
            3'b000:  op = OP_PIO_RD;
            3'b001:  op = OP_PIO_RD_EXT;
            3'b010:  op = OP_DMA_RD;
            3'b011:  op = OP_DMA_RD_EXT;
            3'b100:  op = OP_PIO_WR;
            3'b101:  op = OP_PIO_WR_EXT;
            3'b110:  op = OP_DMA_WR;
            default: op = OP_DMA_WR_EXT;
        endcase
        return op;
    endfunction

endpackage

// File: src/ata_taskfile_command_builder_top.sv
// channel   | signals                                  | handshake
// ----------+------------------------------------------+----------------------------
// request   | start, busy, req                         | taken when start && !busy
// result    | result_strobe, result                    | one write per strobe cycle
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data| taken when valid && ready
//
// a request emits 10 task-file writes in lba48 mode and 6 otherwise, one per cycle,
// so the sequencer's write count sets the request rate.
// first write reaches the result ports through the frame register, then the result
// register, once the request is taken; a request waits in the holding register while
// the previous one writes, and busy is high only while that register is full.
// reset clears the lba flags, holding and sequencer state and the strobe; no stalls.
module ata_taskfile_command_builder_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  atacb_pkg::req_t                  req,
    output logic                             result_strobe,
    output atacb_pkg::result_t               result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [atacb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                             cfg_data
);

    logic               drive0_lba_ok_reg;
    logic               drive1_lba_ok_reg;
    logic               pend_valid_reg, pend_valid_next;
    atacb_pkg::req_t    pend_reg, pend_next;
    logic               active_reg, active_next;
    logic [3:0]         id_reg, id_next;
    atacb_pkg::frame_t  frame_reg, frame_next;
    atacb_pkg::frame_t  frame_built;
    logic               strobe_reg, strobe_next;
    atacb_pkg::result_t result_reg, result_next;
    logic               accept;
    logic               take;

    assign cfg_ready     = 1'b1;
    assign busy          = pend_valid_reg;
    assign accept        = start && !pend_valid_reg;
    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    // lba capability flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive0_lba_ok_reg <= 1'b0;
            drive1_lba_ok_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == atacb_pkg::CFG_DRIVE0_LBA_OK)
                drive0_lba_ok_reg <= cfg_data;
            if (cfg_index == atacb_pkg::CFG_DRIVE1_LBA_OK)
                drive1_lba_ok_reg <= cfg_data;
        end
    end

    // register bytes for the held request
    atacb_frame u_frame (
        .req           (pend_reg),
        .drive0_lba_ok (drive0_lba_ok_reg),
        .drive1_lba_ok (drive1_lba_ok_reg),
        .frame         (frame_built)
    );

    // sequencer hands over on the command write, so requests run without gaps
    assign take = pend_valid_reg && (!active_reg || (id_reg == atacb_pkg::REG_CMD));

    // holding register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (accept)
        begin
            pend_valid_next = 1'b1;
            pend_next       = req;
        end
        else if (take)
        begin
            pend_valid_next = 1'b0;
        end
    end

    // write sequencer stepping through register ids
    always_comb
    begin
        active_next = active_reg;
        id_next     = id_reg;
        frame_next  = frame_reg;
        if (take)
        begin
            active_next = 1'b1;
            id_next     = atacb_pkg::REG_DEVSEL;
            frame_next  = frame_built;
        end
        else if (active_reg)
        begin
            if (id_reg == atacb_pkg::REG_CMD)
                active_next = 1'b0;
            else if (id_reg == atacb_pkg::REG_DEVSEL
                     && frame_reg.mode != atacb_pkg::MODE_LBA48)
                id_next = atacb_pkg::REG_SCNT_LO;
            else
                id_next = id_reg + 4'd1;
        end
    end

    // result byte for the current register id
    always_comb
    begin
        strobe_next            = active_reg;
        result_next.reg_id     = id_reg;
        result_next.addr_mode  = frame_reg.mode;
        result_next.last_write = (id_reg == atacb_pkg::REG_CMD);
        unique case (id_reg)
            atacb_pkg::REG_DEVSEL:  result_next.reg_value = frame_reg.devsel;
            atacb_pkg::REG_SCNT_HI: result_next.reg_value = 8'h00;
            atacb_pkg::REG_LBA3:    result_next.reg_value = frame_reg.lba3;
            atacb_pkg::REG_LBA4:    result_next.reg_value = 8'h00;
            atacb_pkg::REG_LBA5:    result_next.reg_value = 8'h00;
            atacb_pkg::REG_SCNT_LO: result_next.reg_value = frame_reg.scnt_lo;
            atacb_pkg::REG_LBA0:    result_next.reg_value = frame_reg.lba0;
            atacb_pkg::REG_LBA1:    result_next.reg_value = frame_reg.lba1;
            atacb_pkg::REG_LBA2:    result_next.reg_value = frame_reg.lba2;
            atacb_pkg::REG_CMD:     result_next.reg_value = frame_reg.opcode;
            default:                result_next.reg_value = 8'h00;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            active_reg     <= 1'b0;
            id_reg         <= atacb_pkg::REG_DEVSEL;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            active_reg     <= active_next;
            id_reg         <= id_next;
            strobe_reg     <= strobe_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        frame_reg  <= frame_next;
        result_reg <= result_next;
    end

endmodule

// File: src/atacb_frame.sv
module atacb_frame (
    input  atacb_pkg::req_t   req,
    input  logic              drive0_lba_ok,
    input  logic              drive1_lba_ok,
    output atacb_pkg::frame_t frame
);

    logic                               lba_ok;
    logic [atacb_pkg::PROD_W-1:0]       prod;
    logic [atacb_pkg::QUOT_W-1:0]       quot;
    logic [5:0]                         rem;
    logic [7:0]                         sect;
    logic [15:0]                        cyl;
    logic [3:0]                         head;
    logic                               ext;

    assign lba_ok = req.drive_sel ? drive1_lba_ok : drive0_lba_ok;
    assign ext    = (req.sector_addr >= atacb_pkg::LBA48_START);

    // track number = addr / 63 by reciprocal multiply
    assign prod = atacb_pkg::PROD_W'(req.sector_addr[atacb_pkg::CHS_ADDR_W-1:0])
                * atacb_pkg::PROD_W'(atacb_pkg::RECIP_63);
    assign quot = prod[atacb_pkg::PROD_W-1:atacb_pkg::RECIP_SHIFT];

    // remainder is below 64, so addr - 63*q only needs the low six bits
    assign rem  = req.sector_addr[5:0] + quot[5:0];
    assign sect = {2'b00, rem} + 8'd1;
    // 16 heads per cylinder: head and cylinder split the track number
    assign head = quot[3:0];
    assign cyl  = quot[19:4];

    // mode select and register bytes
    always_comb
    begin
        frame.scnt_lo = req.sector_count;
        frame.opcode  = atacb_pkg::opcode_sel(req.is_write, req.use_dma, ext);
        if (ext)
        begin
            frame.mode   = atacb_pkg::MODE_LBA48;
            frame.devsel = atacb_pkg::DEVSEL_LBA | {3'b000, req.drive_sel, 4'h0};
            frame.lba0   = req.sector_addr[7:0];
            frame.lba1   = req.sector_addr[15:8];
            frame.lba2   = req.sector_addr[23:16];
            frame.lba3   = req.sector_addr[31:24];
        end
        else if (lba_ok)
        begin
            frame.mode   = atacb_pkg::MODE_LBA28;
            frame.devsel = atacb_pkg::DEVSEL_LBA | {3'b000, req.drive_sel, 4'h0}
                         | {4'h0, req.sector_addr[27:24]};
            frame.lba0   = req.sector_addr[7:0];
            frame.lba1   = req.sector_addr[15:8];
            frame.lba2   = req.sector_addr[23:16];
            frame.lba3   = 8'h00;
        end
        else
        begin
            frame.mode   = atacb_pkg::MODE_CHS;
            frame.devsel = atacb_pkg::DEVSEL_CHS | {3'b000, req.drive_sel, 4'h0}
                         | {4'h0, head};
            frame.lba0   = sect;
            frame.lba1   = cyl[7:0];
            frame.lba2   = cyl[15:8];
            frame.lba3   = 8'h00;
        end
    end

endmodule
